[rtl/core/slfl_pkg.sv]
package slfl_pkg;

   // Node store geometry. Null is coded as the value NODES.
   localparam int NODES  = 16;
   localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int NODE_W = $clog2(NODES + 1);

   localparam int KEY_W    = 56;
   localparam int PAY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int ENTRY_W  = KEY_W + PAY_W;

   localparam logic [NODE_W-1:0] NIL = NODE_W'(NODES);

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_POP    = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Any link value outside the node range is treated as null.
   function automatic logic [NODE_W-1:0] norm_link(input logic [NODE_W-1:0] v);
      return (v < NIL) ? v : NIL;
   endfunction

endpackage

[rtl/core/slfl_ram.sv]
module slfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/sorted_list_with_free_list_core.sv]
// Channel   | Ports                                          | Direction
// ----------+------------------------------------------------+----------
// request   | req_valid, req_stall, req_command, req_key,    | in
//           | req_payload                                    |
// response  | rsp_valid, rsp_stall, rsp_status, rsp_out_key, | out
//           | rsp_out_payload, rsp_stored_count              |
//
// An insert walks the list and compares the key of at most NODES stored nodes.
// The walk is set by the single key comparator and the one read port of the
// node memory: one node is read and compared per cycle.
// Each request word gives exactly one response word.
// Reset is synchronous and needs no clearing pass: the link table is reset
// directly, and node keys and payloads are only read once written.
// A stalled response word holds the sequencer in its final state; a new request
// is taken while an earlier response still waits.
module sorted_list_with_free_list_core (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [slfl_pkg::KEY_W-1:0]         req_key,
   input  logic [slfl_pkg::PAY_W-1:0]         req_payload,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [slfl_pkg::STATUS_W-1:0]      rsp_status,
   output logic [slfl_pkg::KEY_W-1:0]         rsp_out_key,
   output logic [slfl_pkg::PAY_W-1:0]         rsp_out_payload,
   output logic [slfl_pkg::COUNT_W-1:0]       rsp_stored_count
);

   import slfl_pkg::*;

   // The sequencer: IDLE takes a word, CMP walks the sorted list one node per
   // cycle, ALLOC links a free node in or reports full, POP unlinks the head node or reports empty.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_ALLOC,
      ST_POP
   } state_type;

   state_type            state_ff, state_in;

   // The request word being worked on.
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [PAY_W-1:0]     pay_ff, pay_in;

   // Walk pointers: cur is the node being compared, prev the one before it.
   logic [NODE_W-1:0]    cur_ff, cur_in;
   logic [NODE_W-1:0]    prev_ff, prev_in;
   logic [NODE_W-1:0]    steps_ff, steps_in;

   // List state. The link table lives in flip-flops because reset gives it a
   // defined value for every node.
   logic [NODE_W-1:0]    list_head_ff, list_head_in;
   logic [NODE_W-1:0]    free_head_ff, free_head_in;
   logic [NODE_W-1:0]    entry_count_ff, entry_count_in;
   logic [NODE_W-1:0]    node_link_ff [NODES];
   logic [NODE_W-1:0]    node_link_in [NODES];

   // Response word register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [PAY_W-1:0]     rsp_pay_ff, rsp_pay_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // Node memory port signals (key and payload share one entry).
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [ENTRY_W-1:0]   ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_rd_data;
   logic [KEY_W-1:0]     ram_rd_key;
   logic [PAY_W-1:0]     ram_rd_pay;

   logic                 out_free;
   logic                 key_greater;
   logic [NODE_W-1:0]    next_cur;
   logic [NODE_W-1:0]    steps_next;

   slfl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_key  = ram_rd_data[ENTRY_W-1 -: KEY_W];
   assign ram_rd_pay  = ram_rd_data[PAY_W-1:0];
   assign ram_wr_data = {key_ff, pay_ff};
   assign ram_wr_addr = free_head_ff[IDX_W-1:0];

   // The one shared comparator: the walk goes on while the new key is larger.
   assign key_greater = key_ff > ram_rd_key;
   assign next_cur    = norm_link(node_link_ff[cur_ff[IDX_W-1:0]]);
   assign steps_next  = steps_ff + NODE_W'(1);

   // The final states may only finish when the response register can load.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      pay_in         = pay_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      steps_in       = steps_ff;
      list_head_in   = list_head_ff;
      free_head_in   = free_head_ff;
      entry_count_in = entry_count_ff;
      node_link_in   = node_link_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_pay_in     = rsp_pay_ff;
      rsp_count_in   = rsp_count_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = list_head_ff[IDX_W-1:0];
      ram_wr_en      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in = req_key;
               pay_in = req_payload;
               if (req_command == CMD_POP) begin
                  state_in = ST_POP;
                  // Fetch the head entry now; an empty list is reported in POP.
                  ram_rd_en = (list_head_ff != NIL);
               end else begin
                  prev_in  = NIL;
                  cur_in   = list_head_ff;
                  steps_in = '0;
                  if (list_head_ff != NIL) begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_CMP;
                  end else begin
                     state_in  = ST_ALLOC;
                  end
               end
            end
         end

         ST_CMP: begin
            // The entry of cur is in the read register. Stopping before the
            // first key that is not smaller puts equal keys ahead of old ones.
            if (key_greater) begin
               prev_in  = cur_ff;
               cur_in   = next_cur;
               steps_in = steps_next;
               if (next_cur != NIL && steps_next < NODE_W'(NODES)) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = next_cur[IDX_W-1:0];
               end else begin
                  state_in = ST_ALLOC;
               end
            end else begin
               state_in = ST_ALLOC;
            end
         end

         ST_ALLOC: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_key_in   = '0;
               rsp_pay_in   = '0;
               if (free_head_ff == NIL) begin
                  rsp_status_in = STATUS_FULL;
                  rsp_count_in  = COUNT_W'(entry_count_ff);
               end else begin
                  // Take the free head, fill it and splice it in after prev.
                  ram_wr_en      = 1'b1;
                  free_head_in   = norm_link(node_link_ff[free_head_ff[IDX_W-1:0]]);
                  node_link_in[free_head_ff[IDX_W-1:0]] = cur_ff;
                  if (prev_ff == NIL) begin
                     list_head_in = free_head_ff;
                  end else begin
                     node_link_in[prev_ff[IDX_W-1:0]] = free_head_ff;
                  end
                  entry_count_in = entry_count_ff + NODE_W'(1);
                  rsp_status_in  = STATUS_DONE;
                  rsp_count_in   = COUNT_W'(entry_count_ff + NODE_W'(1));
               end
            end
         end

         ST_POP: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (list_head_ff == NIL) begin
                  rsp_status_in = STATUS_EMPTY;
                  rsp_key_in    = '0;
                  rsp_pay_in    = '0;
                  rsp_count_in  = COUNT_W'(entry_count_ff);
               end else begin
                  // Unlink the head and push it onto the free list.
                  list_head_in = norm_link(node_link_ff[list_head_ff[IDX_W-1:0]]);
                  node_link_in[list_head_ff[IDX_W-1:0]] = free_head_ff;
                  free_head_in = list_head_ff;
                  if (entry_count_ff != '0) begin
                     entry_count_in = entry_count_ff - NODE_W'(1);
                     rsp_count_in   = COUNT_W'(entry_count_ff - NODE_W'(1));
                  end else begin
                     rsp_count_in   = COUNT_W'(entry_count_ff);
                  end
                  rsp_status_in = STATUS_DONE;
                  rsp_key_in    = ram_rd_key;
                  rsp_pay_in    = ram_rd_pay;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         list_head_ff   <= NIL;
         free_head_ff   <= NODE_W'(NODES - 1);
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NODES; i++) begin
            node_link_ff[i] <= (i == 0) ? NIL : NODE_W'(i - 1);
         end
      end else begin
         state_ff       <= state_in;
         list_head_ff   <= list_head_in;
         free_head_ff   <= free_head_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         node_link_ff   <= node_link_in;
      end
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_key      = rsp_key_ff;
   assign rsp_out_payload  = rsp_pay_ff;
   assign rsp_stored_count = rsp_count_ff;

   // The count can never pass the number of nodes.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= NODE_W'(NODES))
      else $error("entry count above node count");

   // An empty list and a zero count always go together.
   a_count_head: assert property (@(posedge clock) disable iff (reset)
      (list_head_ff == NIL) == (entry_count_ff == '0))
      else $error("list head and entry count disagree");

   // A node is never at the head of both lists.
   a_heads_apart: assert property (@(posedge clock) disable iff (reset)
      list_head_ff != free_head_ff)
      else $error("list head equals free head");

   // A new response word only comes out of the two finishing states.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_ALLOC || $past(state_ff) == ST_POP))
      else $error("response word raised outside a finishing state");

   // An accepted insert either walks or goes straight to allocation.
   a_insert_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command == CMD_INSERT)
         |=> (state_ff == ST_CMP || state_ff == ST_ALLOC))
      else $error("insert did not start a walk");

endmodule
